/* hdl/mdrc_pkg.sv */
// shared constants, types and calibration tables of the dual side motor drive
`default_nettype none

package mdrc_pkg;

  localparam int unsigned PWM_PERIOD = 3599;

  localparam int unsigned CMD_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COAST_W    = 16;
  localparam int unsigned DUTY_W     = 12;
  localparam int unsigned APPLIED_W  = 13;

  localparam int unsigned NUM_WHEELS = 4;
  localparam int unsigned WHEEL_W    = 2;
  localparam int unsigned NUM_PTS    = 5;
  localparam int unsigned PT_IDX_W   = 3;
  localparam int unsigned NUM_SEG    = 4;
  localparam int unsigned SEG_W      = 2;

  // numerator of the interpolation stays below 2**PROD_W
  localparam int unsigned PROD_W       = 23;
  localparam int unsigned RECIP_W      = 28;
  localparam int unsigned RECIP_SHIFT  = 35;
  localparam int unsigned QUOT_PROD_W  = PROD_W + RECIP_W;

  localparam logic [COAST_W-1:0] COAST_RESET = COAST_W'(100);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef struct packed {
    logic ld_mid;
    logic ld_out;
  } pipe_ctl_t;

  localparam logic [DUTY_W-1:0] REQ_PTS [NUM_PTS] = '{
    12'd0, 12'd2200, 12'd2400, 12'd3000, 12'd3599
  };

  localparam logic [DUTY_W-1:0] WHEEL_PTS [NUM_WHEELS][NUM_PTS] = '{
    '{12'd0, 12'd2174, 12'd2371, 12'd2962, 12'd3599},
    '{12'd0, 12'd2208, 12'd2410, 12'd3009, 12'd3599},
    '{12'd0, 12'd2210, 12'd2412, 12'd3018, 12'd3599},
    '{12'd0, 12'd2208, 12'd2408, 12'd3012, 12'd3599}
  };

  localparam int unsigned SPAN [NUM_SEG] = '{
    int'(REQ_PTS[1]) - int'(REQ_PTS[0]),
    int'(REQ_PTS[2]) - int'(REQ_PTS[1]),
    int'(REQ_PTS[3]) - int'(REQ_PTS[2]),
    int'(REQ_PTS[4]) - int'(REQ_PTS[3])
  };

  localparam logic [DUTY_W-1:0] HALF_SPAN [NUM_SEG] = '{
    DUTY_W'(SPAN[0] / 2), DUTY_W'(SPAN[1] / 2),
    DUTY_W'(SPAN[2] / 2), DUTY_W'(SPAN[3] / 2)
  };

  // rounded-up reciprocals, exact floor division for numerators below 2**PROD_W
  localparam logic [RECIP_W-1:0] RECIP [NUM_SEG] = '{
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SPAN[0]) - 64'd1) / 64'(SPAN[0])),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SPAN[1]) - 64'd1) / 64'(SPAN[1])),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SPAN[2]) - 64'd1) / 64'(SPAN[2])),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SPAN[3]) - 64'd1) / 64'(SPAN[3]))
  };

endpackage

`default_nettype wire

/* hdl/dual_side_motor_drive_with_reverse_coast_core.sv */
// top level of the dual side motor drive: side lanes, wheel lanes and output merge
//
//   channel | direction | handshake               | payload
//   in      | into      | in_valid_i / in_stall_o   | left/right command, now_ms
//   out     | out of    | out_valid_o / out_stall_i | eight duties, two applied
//   cfg     | into      | cfg_valid_i / cfg_ready_o | coast_time_ms
//
// one transaction per cycle unless a stalled output backs up; each result passes the s1, mid and out registers
// coast state of both sides is updated in the accept cycle, so items follow back to back
// two wheel stages: calibration multiply, then reciprocal divide and output register
// reset puts both sides into coast with the timer unarmed and clears valid bits, coast time returns to 100 ms
// a stalled output only holds the input once every stage is occupied
`default_nettype none

module dual_side_motor_drive_with_reverse_coast_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,

  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [mdrc_pkg::CMD_W-1:0]      left_command_i,
  input  wire logic signed [mdrc_pkg::CMD_W-1:0]      right_command_i,
  input  wire logic        [mdrc_pkg::TIME_W-1:0]     now_ms_i,

  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic        [mdrc_pkg::COAST_W-1:0]    cfg_coast_time_ms_i,

  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [mdrc_pkg::DUTY_W-1:0]                 left_front_forward_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 left_front_reverse_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 left_rear_forward_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 left_rear_reverse_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 right_front_forward_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 right_front_reverse_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 right_rear_forward_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 right_rear_reverse_duty_o,
  output logic signed [mdrc_pkg::APPLIED_W-1:0]       left_applied_o,
  output logic signed [mdrc_pkg::APPLIED_W-1:0]       right_applied_o
);

  logic [mdrc_pkg::COAST_W-1:0] coast_q;

  logic v1_q, v1_d, v2_q, v2_d, vo_q, vo_d;
  logic go_out, go_mid, go_s1, accept;
  mdrc_pkg::pipe_ctl_t ctl;

  logic signed [mdrc_pkg::APPLIED_W-1:0] left_app, right_app;
  logic signed [mdrc_pkg::APPLIED_W-1:0] left_s1_q, right_s1_q;
  logic signed [mdrc_pkg::APPLIED_W-1:0] left_mid_q, right_mid_q;
  logic signed [mdrc_pkg::APPLIED_W-1:0] left_out_q, right_out_q;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coast_q <= mdrc_pkg::COAST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      coast_q <= cfg_coast_time_ms_i;
    end
  end

  // pipeline flow
  assign go_out     = !vo_q || !out_stall_i;
  assign go_mid     = !v2_q || go_out;
  assign go_s1      = !v1_q || go_mid;
  assign in_stall_o = !go_s1;
  assign accept     = in_valid_i && go_s1;
  assign ctl.ld_mid = v1_q && go_mid;
  assign ctl.ld_out = v2_q && go_out;

  assign v1_d = accept     || (v1_q && !go_mid);
  assign v2_d = ctl.ld_mid || (v2_q && !go_out);
  assign vo_d = ctl.ld_out || (vo_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      vo_q <= vo_d;
    end
  end

  mdrc_side_lane u_side_left (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (left_command_i),
    .now_i        (now_ms_i),
    .coast_time_i (coast_q),
    .applied_o    (left_app)
  );

  mdrc_side_lane u_side_right (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (right_command_i),
    .now_i        (now_ms_i),
    .coast_time_i (coast_q),
    .applied_o    (right_app)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_s1_q  <= left_app;
      right_s1_q <= right_app;
    end
    if (ctl.ld_mid) begin
      left_mid_q  <= left_s1_q;
      right_mid_q <= right_s1_q;
    end
    if (ctl.ld_out) begin
      left_out_q  <= left_mid_q;
      right_out_q <= right_mid_q;
    end
  end

  mdrc_wheel_lane u_wheel_lf (
    .clk_i      (clk_i),
    .wheel_i    (2'd0),
    .ctl_i      (ctl),
    .applied_i  (left_s1_q),
    .fwd_duty_o (left_front_forward_duty_o),
    .rev_duty_o (left_front_reverse_duty_o)
  );

  mdrc_wheel_lane u_wheel_lr (
    .clk_i      (clk_i),
    .wheel_i    (2'd1),
    .ctl_i      (ctl),
    .applied_i  (left_s1_q),
    .fwd_duty_o (left_rear_forward_duty_o),
    .rev_duty_o (left_rear_reverse_duty_o)
  );

  mdrc_wheel_lane u_wheel_rf (
    .clk_i      (clk_i),
    .wheel_i    (2'd2),
    .ctl_i      (ctl),
    .applied_i  (right_s1_q),
    .fwd_duty_o (right_front_forward_duty_o),
    .rev_duty_o (right_front_reverse_duty_o)
  );

  mdrc_wheel_lane u_wheel_rr (
    .clk_i      (clk_i),
    .wheel_i    (2'd3),
    .ctl_i      (ctl),
    .applied_i  (right_s1_q),
    .fwd_duty_o (right_rear_forward_duty_o),
    .rev_duty_o (right_rear_reverse_duty_o)
  );

  assign out_valid_o     = vo_q;
  assign left_applied_o  = left_out_q;
  assign right_applied_o = right_out_q;

endmodule

`default_nettype wire

/* hdl/mdrc_side_lane.sv */
// one side: command clamp, direction tracking and reverse coast timing
`default_nettype none

module mdrc_side_lane (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        accept_i,
  input  wire logic signed [mdrc_pkg::CMD_W-1:0]           cmd_i,
  input  wire logic        [mdrc_pkg::TIME_W-1:0]          now_i,
  input  wire logic        [mdrc_pkg::COAST_W-1:0]         coast_time_i,
  output logic      signed [mdrc_pkg::APPLIED_W-1:0]       applied_o
);

  localparam logic signed [mdrc_pkg::CMD_W-1:0] CMD_MAX =
    mdrc_pkg::CMD_W'(mdrc_pkg::PWM_PERIOD);

  mdrc_pkg::dir_e                   committed_q, committed_d;
  logic                             active_q, active_d;
  logic [mdrc_pkg::TIME_W-1:0]      start_q, start_d;
  logic                             timed_q, timed_d;

  logic signed [mdrc_pkg::CMD_W-1:0] clamped;
  mdrc_pkg::dir_e                   dir;
  logic [mdrc_pkg::TIME_W-1:0]      elapsed;
  logic                             too_soon;

  always_comb begin
    if (cmd_i > CMD_MAX) begin
      clamped = CMD_MAX;
    end else if (cmd_i < -CMD_MAX) begin
      clamped = -CMD_MAX;
    end else begin
      clamped = cmd_i;
    end
  end

  always_comb begin
    if (clamped > 0) begin
      dir = mdrc_pkg::DIR_FWD;
    end else if (clamped < 0) begin
      dir = mdrc_pkg::DIR_REV;
    end else begin
      dir = mdrc_pkg::DIR_NONE;
    end
  end

  // unsigned wrap on the time difference
  assign elapsed  = now_i - start_q;
  assign too_soon = elapsed < {{(mdrc_pkg::TIME_W - mdrc_pkg::COAST_W){1'b0}}, coast_time_i};

  always_comb begin
    committed_d = committed_q;
    active_d    = active_q;
    start_d     = start_q;
    timed_d     = timed_q;
    applied_o   = '0;
    if (dir == mdrc_pkg::DIR_NONE || (dir != committed_q && !active_q)) begin
      if (!active_q) begin
        start_d = now_i;
        timed_d = 1'b1;
      end
      active_d = 1'b1;
    end else if (dir != committed_q && timed_q && too_soon) begin
      applied_o = '0;
    end else begin
      active_d    = 1'b0;
      committed_d = dir;
      applied_o   = clamped[mdrc_pkg::APPLIED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= mdrc_pkg::DIR_NONE;
      active_q    <= 1'b1;
      start_q     <= '0;
      timed_q     <= 1'b0;
    end else if (accept_i) begin
      committed_q <= committed_d;
      active_q    <= active_d;
      start_q     <= start_d;
      timed_q     <= timed_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/mdrc_wheel_lane.sv */
// one wheel: piecewise-linear calibration with rounded division, two stages
`default_nettype none

module mdrc_wheel_lane (
  input  wire logic                                   clk_i,
  input  wire logic [mdrc_pkg::WHEEL_W-1:0]           wheel_i,
  input  wire mdrc_pkg::pipe_ctl_t                    ctl_i,
  input  wire logic signed [mdrc_pkg::APPLIED_W-1:0]  applied_i,
  output logic [mdrc_pkg::DUTY_W-1:0]                 fwd_duty_o,
  output logic [mdrc_pkg::DUTY_W-1:0]                 rev_duty_o
);

  localparam logic [mdrc_pkg::DUTY_W-1:0] PERIOD = mdrc_pkg::DUTY_W'(mdrc_pkg::PWM_PERIOD);
  localparam logic [mdrc_pkg::PT_IDX_W-1:0] LAST_PT =
    mdrc_pkg::PT_IDX_W'(mdrc_pkg::NUM_PTS - 1);

  logic [mdrc_pkg::APPLIED_W-1:0]   mag_full;
  logic [mdrc_pkg::DUTY_W-1:0]      mag;
  logic [mdrc_pkg::SEG_W-1:0]       seg;
  logic [mdrc_pkg::PT_IDX_W-1:0]    lo_idx, hi_idx;
  logic [mdrc_pkg::DUTY_W-1:0]      off, rise;
  logic [2*mdrc_pkg::DUTY_W-1:0]    prod_full;
  logic [mdrc_pkg::PROD_W-1:0]      num_d;

  logic [mdrc_pkg::PROD_W-1:0]      num_q;
  logic [mdrc_pkg::SEG_W-1:0]       seg_q;
  logic [mdrc_pkg::DUTY_W-1:0]      base_q;
  logic                             sat_q, over_q, pos_q, neg_q;

  logic [mdrc_pkg::QUOT_PROD_W-1:0] quot_prod;
  logic [mdrc_pkg::DUTY_W-1:0]      quot, duty;
  logic [mdrc_pkg::DUTY_W-1:0]      fwd_q, rev_q;

  assign mag_full = applied_i[mdrc_pkg::APPLIED_W-1] ? -applied_i : applied_i;
  assign mag      = mag_full[mdrc_pkg::DUTY_W-1:0];

  always_comb begin
    priority if (mag <= mdrc_pkg::REQ_PTS[1]) begin
      seg = 2'd0;
    end else if (mag <= mdrc_pkg::REQ_PTS[2]) begin
      seg = 2'd1;
    end else if (mag <= mdrc_pkg::REQ_PTS[3]) begin
      seg = 2'd2;
    end else begin
      seg = 2'd3;
    end
  end

  assign lo_idx    = {1'b0, seg};
  assign hi_idx    = lo_idx + 3'd1;
  assign off       = mag - mdrc_pkg::REQ_PTS[lo_idx];
  assign rise      = mdrc_pkg::WHEEL_PTS[wheel_i][hi_idx] - mdrc_pkg::WHEEL_PTS[wheel_i][lo_idx];
  assign prod_full = off * rise;
  assign num_d     = prod_full[mdrc_pkg::PROD_W-1:0]
                   + {{(mdrc_pkg::PROD_W - mdrc_pkg::DUTY_W){1'b0}}, mdrc_pkg::HALF_SPAN[seg]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_mid) begin
      num_q  <= num_d;
      seg_q  <= seg;
      base_q <= mdrc_pkg::WHEEL_PTS[wheel_i][lo_idx];
      sat_q  <= mag >= PERIOD;
      over_q <= mag > mdrc_pkg::REQ_PTS[LAST_PT];
      pos_q  <= applied_i > 0;
      neg_q  <= applied_i < 0;
    end
  end

  // division by the segment span as a reciprocal multiply
  assign quot_prod = num_q * mdrc_pkg::RECIP[seg_q];
  assign quot      = quot_prod[mdrc_pkg::RECIP_SHIFT +: mdrc_pkg::DUTY_W];

  always_comb begin
    if (sat_q) begin
      duty = PERIOD;
    end else if (over_q) begin
      duty = mdrc_pkg::WHEEL_PTS[wheel_i][LAST_PT];
    end else begin
      duty = base_q + quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      fwd_q <= pos_q ? duty : '0;
      rev_q <= neg_q ? duty : '0;
    end
  end

  assign fwd_duty_o = fwd_q;
  assign rev_duty_o = rev_q;

endmodule

`default_nettype wire

/* tb/motor_drive_checker.sv */
// checker for the dual side motor drive: predicts every result from the accepted commands and compares it
module motor_drive_checker
  import mdrc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [CMD_W-1:0]            left_command_i,
  input  logic [CMD_W-1:0]            right_command_i,
  input  logic [TIME_W-1:0]           now_ms_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [COAST_W-1:0]          cfg_coast_time_ms_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [DUTY_W-1:0]           left_front_forward_duty_i,
  input  logic [DUTY_W-1:0]           left_front_reverse_duty_i,
  input  logic [DUTY_W-1:0]           left_rear_forward_duty_i,
  input  logic [DUTY_W-1:0]           left_rear_reverse_duty_i,
  input  logic [DUTY_W-1:0]           right_front_forward_duty_i,
  input  logic [DUTY_W-1:0]           right_front_reverse_duty_i,
  input  logic [DUTY_W-1:0]           right_rear_forward_duty_i,
  input  logic [DUTY_W-1:0]           right_rear_reverse_duty_i,
  input  logic [APPLIED_W-1:0]        left_applied_i,
  input  logic [APPLIED_W-1:0]        right_applied_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [9:0][APPLIED_W-1:0] drive_word_t;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned CMD_KNOTS [5] = '{0, 2200, 2400, 3000, 3599};
  localparam int unsigned WHEEL_KNOTS [4][5] = '{
    '{0, 2174, 2371, 2962, 3599},
    '{0, 2208, 2410, 3009, 3599},
    '{0, 2210, 2412, 3018, 3599},
    '{0, 2208, 2408, 3012, 3599}
  };

  string field_names [10] = '{
    "left_front_forward_duty", "left_front_reverse_duty",
    "left_rear_forward_duty", "left_rear_reverse_duty",
    "right_front_forward_duty", "right_front_reverse_duty",
    "right_rear_forward_duty", "right_rear_reverse_duty",
    "left_applied", "right_applied"
  };

  dir_e               side_dir    [2];
  logic               coasting    [2];
  logic [TIME_W-1:0]  coast_from  [2];
  logic               coast_armed [2];
  logic [COAST_W-1:0] coast_ms;
  drive_word_t        expected_q [$];
  drive_word_t        got;
  drive_word_t        want;
  drive_word_t        predicted;

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic int limit_cmd(logic [CMD_W-1:0] raw);
    int v;
    v = int'($signed(raw));
    if (v > int'(PWM_PERIOD)) v = PWM_PERIOD;
    if (v < -int'(PWM_PERIOD)) v = -int'(PWM_PERIOD);
    return v;
  endfunction

  function automatic logic [DUTY_W-1:0] calibrate(int unsigned wheel, int unsigned mag);
    int unsigned span;
    int unsigned rise;
    if (mag >= PWM_PERIOD) return DUTY_W'(PWM_PERIOD);
    for (int unsigned seg = 1; seg < 5; seg++) begin
      if (mag <= CMD_KNOTS[seg]) begin
        span = CMD_KNOTS[seg] - CMD_KNOTS[seg-1];
        rise = WHEEL_KNOTS[wheel][seg] - WHEEL_KNOTS[wheel][seg-1];
        return DUTY_W'(WHEEL_KNOTS[wheel][seg-1] +
                       ((mag - CMD_KNOTS[seg-1]) * rise + span / 2) / span);
      end
    end
    return DUTY_W'(WHEEL_KNOTS[wheel][4]);
  endfunction

  // coast bookkeeping of one side, returns the command that reaches the wheels
  task automatic settle_side(input int s, input int cmd, input logic [TIME_W-1:0] stamp,
                             output int applied);
    dir_e              dir;
    logic [TIME_W-1:0] waited;
    dir = cmd > 0 ? DIR_FWD : (cmd < 0 ? DIR_REV : DIR_NONE);
    waited = stamp - coast_from[s];
    if (dir == DIR_NONE || (dir != side_dir[s] && !coasting[s])) begin
      if (!coasting[s]) begin
        coast_from[s] = stamp;
        coast_armed[s] = 1'b1;
      end
      coasting[s] = 1'b1;
      applied = 0;
    end else if (dir != side_dir[s] && coast_armed[s] && waited < TIME_W'(coast_ms)) begin
      applied = 0;
    end else begin
      coasting[s] = 1'b0;
      side_dir[s] = dir;
      applied = cmd;
    end
  endtask

  task automatic predict_drive(input logic [CMD_W-1:0] left_raw, input logic [CMD_W-1:0] right_raw,
                               input logic [TIME_W-1:0] stamp, output drive_word_t res);
    int          cmd [2];
    int unsigned mag;
    int unsigned wheel;
    logic [DUTY_W-1:0] duty;
    settle_side(0, limit_cmd(left_raw), stamp, cmd[0]);
    settle_side(1, limit_cmd(right_raw), stamp, cmd[1]);
    for (int s = 0; s < 2; s++) begin
      mag = cmd[s] < 0 ? -cmd[s] : cmd[s];
      for (int k = 0; k < 2; k++) begin
        wheel = s * 2 + k;
        duty = calibrate(wheel, mag);
        res[wheel*2]   = cmd[s] > 0 ? APPLIED_W'(duty) : '0;
        res[wheel*2+1] = cmd[s] < 0 ? APPLIED_W'(duty) : '0;
      end
    end
    res[8] = APPLIED_W'(cmd[0]);
    res[9] = APPLIED_W'(cmd[1]);
  endtask

  task automatic log_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coast_ms = COAST_RESET;
      for (int s = 0; s < 2; s++) begin
        side_dir[s] = DIR_NONE;
        coasting[s] = 1'b1;
        coast_from[s] = '0;
        coast_armed[s] = 1'b0;
      end
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) coast_ms = cfg_coast_time_ms_i;
      if (out_valid_i && !out_stall_i) begin
        got[0] = APPLIED_W'(left_front_forward_duty_i);
        got[1] = APPLIED_W'(left_front_reverse_duty_i);
        got[2] = APPLIED_W'(left_rear_forward_duty_i);
        got[3] = APPLIED_W'(left_rear_reverse_duty_i);
        got[4] = APPLIED_W'(right_front_forward_duty_i);
        got[5] = APPLIED_W'(right_front_reverse_duty_i);
        got[6] = APPLIED_W'(right_rear_forward_duty_i);
        got[7] = APPLIED_W'(right_rear_reverse_duty_i);
        got[8] = left_applied_i;
        got[9] = right_applied_i;
        if (expected_q.size() == 0) begin
          log_failure($sformatf("result with no command outstanding: 0x%h", got));
        end else begin
          want = expected_q.pop_front();
          for (int f = 0; f < 10; f++) begin
            if (got[f] !== want[f]) begin
              log_failure($sformatf("%s expected 0x%h got 0x%h",
                                    field_names[f], want[f], got[f]));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_drive(left_command_i, right_command_i, now_ms_i, predicted);
        expected_q.push_back(predicted);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/dual_side_motor_drive_with_reverse_coast_core_tb.sv */
// testbench top for the dual side motor drive: stimulus, handshake pacing and verdict
module dual_side_motor_drive_with_reverse_coast_core_tb;
  import mdrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CMD_W-1:0]  left;
    logic [CMD_W-1:0]  right;
    logic [TIME_W-1:0] stamp;
  } drive_cmd_t;

  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [CMD_W-1:0] EDGE_CMDS [12] = '{
    16'h7FFF, 16'h8000, CMD_W'(3599), CMD_W'(3600), CMD_W'(-3599), CMD_W'(-3600),
    CMD_W'(1), CMD_W'(-1), CMD_W'(2200), CMD_W'(2400), CMD_W'(3000), CMD_W'(-2201)
  };

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     left_command_i = '0;
  logic [CMD_W-1:0]     right_command_i = '0;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [COAST_W-1:0]   cfg_coast_time_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DUTY_W-1:0]    left_front_forward_duty_o;
  logic [DUTY_W-1:0]    left_front_reverse_duty_o;
  logic [DUTY_W-1:0]    left_rear_forward_duty_o;
  logic [DUTY_W-1:0]    left_rear_reverse_duty_o;
  logic [DUTY_W-1:0]    right_front_forward_duty_o;
  logic [DUTY_W-1:0]    right_front_reverse_duty_o;
  logic [DUTY_W-1:0]    right_rear_forward_duty_o;
  logic [DUTY_W-1:0]    right_rear_reverse_duty_o;
  logic [APPLIED_W-1:0] left_applied_o;
  logic [APPLIED_W-1:0] right_applied_o;

  int unsigned fail_count;
  int unsigned pending;
  drive_cmd_t  cmd_q [$];
  int unsigned queued_cmds = 0;
  int unsigned accepted_cmds = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;
  logic        src_steady = 1'b0;
  logic        sink_steady = 1'b0;

  dual_side_motor_drive_with_reverse_coast_core uut (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .in_valid_i                 (in_valid_i),
    .in_stall_o                 (in_stall_o),
    .left_command_i             (left_command_i),
    .right_command_i            (right_command_i),
    .now_ms_i                   (now_ms_i),
    .cfg_valid_i                (cfg_valid_i),
    .cfg_ready_o                (cfg_ready_o),
    .cfg_coast_time_ms_i        (cfg_coast_time_ms_i),
    .out_valid_o                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .left_front_forward_duty_o  (left_front_forward_duty_o),
    .left_front_reverse_duty_o  (left_front_reverse_duty_o),
    .left_rear_forward_duty_o   (left_rear_forward_duty_o),
    .left_rear_reverse_duty_o   (left_rear_reverse_duty_o),
    .right_front_forward_duty_o (right_front_forward_duty_o),
    .right_front_reverse_duty_o (right_front_reverse_duty_o),
    .right_rear_forward_duty_o  (right_rear_forward_duty_o),
    .right_rear_reverse_duty_o  (right_rear_reverse_duty_o),
    .left_applied_o             (left_applied_o),
    .right_applied_o            (right_applied_o)
  );

  motor_drive_checker checker_inst (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .in_valid_i                 (in_valid_i),
    .in_stall_i                 (in_stall_o),
    .left_command_i             (left_command_i),
    .right_command_i            (right_command_i),
    .now_ms_i                   (now_ms_i),
    .cfg_valid_i                (cfg_valid_i),
    .cfg_ready_i                (cfg_ready_o),
    .cfg_coast_time_ms_i        (cfg_coast_time_ms_i),
    .out_valid_i                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .left_front_forward_duty_i  (left_front_forward_duty_o),
    .left_front_reverse_duty_i  (left_front_reverse_duty_o),
    .left_rear_forward_duty_i   (left_rear_forward_duty_o),
    .left_rear_reverse_duty_i   (left_rear_reverse_duty_o),
    .right_front_forward_duty_i (right_front_forward_duty_o),
    .right_front_reverse_duty_i (right_front_reverse_duty_o),
    .right_rear_forward_duty_i  (right_rear_forward_duty_o),
    .right_rear_reverse_duty_i  (right_rear_reverse_duty_o),
    .left_applied_i             (left_applied_o),
    .right_applied_i            (right_applied_o),
    .fail_count_o               (fail_count),
    .pending_o                  (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // command sender, one transaction per queued command
  initial begin
    drive_cmd_t  item;
    int unsigned gap;
    forever begin
      @(negedge clk_i);
      if (cmd_q.size() == 0) begin
        in_valid_i = 1'b0;
      end else begin
        gap = src_steady ? 0 : $urandom_range(16);
        if (gap > 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        item = cmd_q.pop_front();
        left_command_i = item.left;
        right_command_i = item.right;
        now_ms_i = item.stamp;
        in_valid_i = 1'b1;
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        accepted_cmds++;
      end
    end
  end

  // result receiver with random and long stalls
  initial begin
    int unsigned hold;
    forever begin
      hold = sink_steady ? 0 : $urandom_range(16);
      if (hold_done != hold_reqs) begin
        hold = LONG_HOLD;
        hold_done++;
      end
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] l, input logic [CMD_W-1:0] r,
                           input logic [TIME_W-1:0] stamp);
    cmd_q.push_back('{left: l, right: r, stamp: stamp});
    queued_cmds++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (accepted_cmds != queued_cmds || pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_coast(input logic [COAST_W-1:0] ms);
    @(negedge clk_i);
    cfg_coast_time_ms_i = ms;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] draw_cmd(logic [CMD_W-1:0] prev);
    int unsigned kind;
    int          mag;
    logic        neg;
    kind = $urandom_range(15);
    if (kind < 3) return '0;
    if (kind == 3) return CMD_W'($urandom);
    if (kind == 4) return EDGE_CMDS[$urandom_range(11)];
    mag = $urandom_range(1, PWM_PERIOD);
    // mostly keep going the way the side already goes
    neg = (kind < 12 && prev != '0) ? prev[CMD_W-1] : 1'($urandom);
    return neg ? CMD_W'(-mag) : CMD_W'(mag);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp(logic [TIME_W-1:0] prev,
                                                   int unsigned coast);
    case ($urandom_range(31))
      0:       return $urandom;
      1:       return prev - $urandom_range(1, 1000);
      2:       return prev + $urandom_range(coast, coast + 100000);
      default: return prev + $urandom_range(0, coast / 3 + 3);
    endcase
  endfunction

  initial begin
    int unsigned       coast;
    logic [TIME_W-1:0] stamp;
    logic [CMD_W-1:0]  last_l;
    logic [CMD_W-1:0]  last_r;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at the reset coast time
    queue_cmd(16'd0, 16'd0, 32'd0);
    queue_cmd(16'h7FFF, 16'h8000, 32'd1);
    queue_cmd(CMD_W'(3599), CMD_W'(-3599), 32'd2);
    queue_cmd(CMD_W'(3600), CMD_W'(-3600), 32'd3);
    queue_cmd(CMD_W'(2200), CMD_W'(-2201), 32'd4);
    queue_cmd(CMD_W'(2400), CMD_W'(-2199), 32'd5);
    queue_cmd(CMD_W'(3000), CMD_W'(-3598), 32'd6);
    queue_cmd(CMD_W'(1), CMD_W'(-1), 32'd7);
    queue_cmd(CMD_W'(-1), CMD_W'(1), 32'd8);
    queue_cmd(CMD_W'(-3000), CMD_W'(3000), 32'd50);
    queue_cmd(CMD_W'(-3000), CMD_W'(3000), 32'd108);
    queue_cmd(CMD_W'(5), CMD_W'(-5), 32'd109);
    queue_cmd(CMD_W'(-2400), CMD_W'(2400), 32'd110);
    queue_cmd(16'd0, 16'd0, 32'd200);
    queue_cmd(16'd0, 16'd0, 32'd290);
    queue_cmd(CMD_W'(7), CMD_W'(-7), 32'd299);
    queue_cmd(CMD_W'(7), CMD_W'(-7), 32'd300);
    queue_cmd(CMD_W'(-9), CMD_W'(9), 32'hFFFF_FFF0);
    queue_cmd(CMD_W'(-9), CMD_W'(9), 32'h0000_0050);
    queue_cmd(CMD_W'(-9), CMD_W'(9), 32'h0000_0054);
    queue_cmd(CMD_W'(2199), CMD_W'(-2199), 32'h0000_0060);
    queue_cmd(CMD_W'(2199), CMD_W'(-2199), 32'h0000_0010);
    queue_cmd(16'h8001, 16'h7FFE, 32'h0000_0011);
    queue_cmd(16'd0, CMD_W'(3599), 32'hFFFF_FFFF);
    wait_drained();

    stamp = '0;
    last_l = '0;
    last_r = '0;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       coast = 0;
        1:       coast = 65535;
        2:       coast = 1;
        4:       coast = 100;
        5:       coast = $urandom_range(65535);
        default: coast = $urandom_range(2, 400);
      endcase
      set_coast(COAST_W'(coast));
      src_steady = (p % 3 == 1);
      sink_steady = (p % 3 == 2);
      // receiver holds off while the sender keeps pushing
      if (p % 3 == 1) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        stamp = next_stamp(stamp, coast);
        last_l = draw_cmd(last_l);
        last_r = draw_cmd(last_r);
        queue_cmd(last_l, last_r, stamp);
      end
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mdrc_pkg.sv
hdl/mdrc_side_lane.sv
hdl/mdrc_wheel_lane.sv
hdl/dual_side_motor_drive_with_reverse_coast_core.sv
tb/motor_drive_checker.sv
tb/dual_side_motor_drive_with_reverse_coast_core_tb.sv
